FILE: rtl/wmf_pkg.sv
// Package for the two-dimensional window maximum filter.
// Register indexes, configuration widths and the limit bundle shared by the
// configuration block and the top level. No dependencies.
`default_nettype none

package wmf_pkg;

	// configuration register indexes
	localparam logic [1:0] REG_FRAME_ROWS    = 2'd0;
	localparam logic [1:0] REG_FRAME_COLS    = 2'd1;
	localparam logic [1:0] REG_WINDOW_HEIGHT = 2'd2;
	localparam logic [1:0] REG_WINDOW_WIDTH  = 2'd3;

	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 16;
	localparam int ROW_BITS       = 16;
	localparam int COLS_BITS      = 11;
	localparam int WIN_BITS       = 4;
	localparam int CORNER_COL_BITS = 10;

	// clamped frame limits, window size with its validity check, config write
	typedef struct packed {
		logic [ROW_BITS-1:0]  rows;
		logic [COLS_BITS-1:0] cols;
		logic [WIN_BITS-1:0]  win_h;
		logic [WIN_BITS-1:0]  win_w;
		logic                 win_ok;
		logic                 cfg_wr;
	} lim_t;

endpackage

`default_nettype wire

FILE: rtl/wmf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the line stores. No dependencies.
`default_nettype none

module wmf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire                                     clk,
	input  wire                                     wr_en,
	input  wire [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  wire [WIDTH-1:0]                         wr_data,
	input  wire                                     rd_en,
	input  wire [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                        rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read, hold when not enabled
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/wmf_cfg.sv
// Configuration registers of the window maximum filter and their clamped limits.
// Depends on wmf_pkg.
`default_nettype none

module wmf_cfg #(
	parameter int MAX_COLS  = 1024,
	parameter int MAX_WIN_H = 8,
	parameter int MAX_WIN_W = 8
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                cfg_we,
	input  wire [wmf_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  wire [wmf_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	output wmf_pkg::lim_t                      lim
);

	import wmf_pkg::*;

	logic [ROW_BITS-1:0]  frame_rows_q;
	logic [COLS_BITS-1:0] frame_cols_q;
	logic [WIN_BITS-1:0]  window_height_q;
	logic [WIN_BITS-1:0]  window_width_q;

	// take register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_rows_q    <= ROW_BITS'(1);
			frame_cols_q    <= COLS_BITS'(1);
			window_height_q <= WIN_BITS'(1);
			window_width_q  <= WIN_BITS'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FRAME_ROWS:    frame_rows_q    <= cfg_data[ROW_BITS-1:0];
				REG_FRAME_COLS:    frame_cols_q    <= cfg_data[COLS_BITS-1:0];
				REG_WINDOW_HEIGHT: window_height_q <= cfg_data[WIN_BITS-1:0];
				REG_WINDOW_WIDTH:  window_width_q  <= cfg_data[WIN_BITS-1:0];
			endcase
		end
	end

	// clamp frame size, check window size
	always_comb begin
		lim.rows  = (frame_rows_q == '0) ? ROW_BITS'(1) : frame_rows_q;
		if (frame_cols_q == '0) begin
			lim.cols = COLS_BITS'(1);
		end else if (32'(frame_cols_q) > 32'(MAX_COLS)) begin
			lim.cols = COLS_BITS'(MAX_COLS);
		end else begin
			lim.cols = frame_cols_q;
		end
		lim.win_h  = window_height_q;
		lim.win_w  = window_width_q;
		lim.win_ok = (window_height_q != '0) && (32'(window_height_q) <= 32'(MAX_WIN_H))
			&& (window_width_q != '0) && (32'(window_width_q) <= 32'(MAX_WIN_W));
		lim.cfg_wr = cfg_we;
	end

endmodule

`default_nettype wire

FILE: rtl/wmf_line_store.sv
// Line stores holding the previous rows of each column, newest row first.
// One wmf_ram per row; write-to-read bypass for back-to-back same-column items.
// Depends on wmf_ram.
`default_nettype none

module wmf_line_store #(
	parameter int VALUE_BITS = 32,
	parameter int ROWS       = 7,
	parameter int DEPTH      = 1024
) (
	input  wire                                        clk,
	input  wire                                        arst_n,
	input  wire                                        rd_en,
	input  wire [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
	input  wire                                        wr_en,
	input  wire [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
	input  wire [VALUE_BITS-1:0]                       px,
	output logic [ROWS-1:0][VALUE_BITS-1:0]            lines
);

	logic [ROWS-1:0][VALUE_BITS-1:0] rd_data;
	logic [ROWS-1:0][VALUE_BITS-1:0] wr_vec;
	logic [ROWS-1:0][VALUE_BITS-1:0] byp_q;
	logic                            byp_q_valid;

	// one RAM per stored row
	for (genvar g = 0; g < ROWS; g++) begin : g_row
		wmf_ram #(
			.WIDTH(VALUE_BITS),
			.DEPTH(DEPTH)
		) u_ram (
			.clk    (clk),
			.wr_en  (wr_en),
			.wr_addr(wr_addr),
			.wr_data(wr_vec[g]),
			.rd_en  (rd_en),
			.rd_addr(rd_addr),
			.rd_data(rd_data[g])
		);
	end

	// select bypassed data, shift the column down by one row
	always_comb begin
		for (int k = 0; k < ROWS; k++) begin
			lines[k] = byp_q_valid ? byp_q[k] : rd_data[k];
		end
		wr_vec[0] = px;
		for (int k = 1; k < ROWS; k++) begin
			wr_vec[k] = lines[k-1];
		end
	end

	// capture the write that lands on the address being read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q_valid <= 1'b0;
		end else if (rd_en) begin
			byp_q_valid <= wr_en && (wr_addr == rd_addr);
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			byp_q <= wr_vec;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/window_max_filter_2d.sv
// Two-dimensional window maximum filter, top level.
// Pixels enter on the s_ stream in raster order, one signed value in s_tdata.
// For each pixel that completes a window of window_height rows by window_width
// columns, one request leaves on the m_ stream: m_tdata holds the maximum, the
// top row and the left column of the window; m_tlast marks the frame's last
// window. Results leave in row-major order of the window corner.
// Configuration is written on cfg_we/cfg_index/cfg_data while idle; any write
// restarts the frame at row 0, column 0.
// Throughput: one pixel per cycle unless a result waits on a stalled m_.
// A result goes from the first stage (line store read) through the compare
// trees into the output register. The line store RAM read sets the first stage.
// When m_tready is low the output register holds, the stage behind it holds
// once it carries a result, and s_tready falls; pixels that make no result
// still pass while the output waits.
// Reset clears the counters and pipeline valids and sets the configuration
// registers to 1; the line stores need no clearing pass since each entry is
// written before it is read within a frame.
// Depends on wmf_pkg, wmf_cfg, wmf_line_store, wmf_ram.
`default_nettype none

module window_max_filter_2d #(
	parameter int MAX_COLS   = 1024,
	parameter int MAX_WIN_H  = 8,
	parameter int MAX_WIN_W  = 8,
	parameter int VALUE_BITS = 32
) (
	input  wire                                           clk,
	input  wire                                           arst_n,
	// pixel stream; s_tdata: pixel_value
	input  wire                                           s_tvalid,
	output logic                                          s_tready,
	input  wire [((VALUE_BITS + 7) / 8) * 8 - 1:0]        s_tdata,
	// result stream; m_tdata: window_max, corner_row, corner_col
	output logic                                          m_tvalid,
	input  wire                                           m_tready,
	output logic [((VALUE_BITS + 26 + 7) / 8) * 8 - 1:0]  m_tdata,
	output logic                                          m_tlast,
	// configuration write port
	input  wire                                           cfg_we,
	input  wire [wmf_pkg::CFG_INDEX_BITS-1:0]             cfg_index,
	input  wire [wmf_pkg::CFG_DATA_BITS-1:0]              cfg_data
);

	import wmf_pkg::*;

	localparam int COL_BITS = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int LS_N     = (MAX_WIN_H > 1) ? MAX_WIN_H - 1 : 1;
	localparam int CM_N     = (MAX_WIN_W > 1) ? MAX_WIN_W - 1 : 1;
	localparam int VT_LVL   = $clog2(LS_N + 1);
	localparam int VT_N     = 1 << VT_LVL;
	localparam int HT_LVL   = $clog2(CM_N + 1);
	localparam int HT_N     = 1 << HT_LVL;
	localparam int OUT_BITS = VALUE_BITS + ROW_BITS + CORNER_COL_BITS;
	localparam int OUT_PAD  = ((OUT_BITS + 7) / 8) * 8;

	lim_t lim;

	logic [ROW_BITS-1:0]  row_q;
	logic [COL_BITS-1:0]  col_q;
	logic                 accept;

	logic                  valid_s1;
	logic [VALUE_BITS-1:0] px_s1;
	logic [ROW_BITS-1:0]   row_s1;
	logic [COL_BITS-1:0]   col_s1;
	logic                  go_s1;
	logic                  vert_ok;
	logic                  horiz_ok;
	logic                  res_s1;
	logic                  out_free;

	logic [LS_N-1:0][VALUE_BITS-1:0] lines;
	logic [CM_N-1:0][VALUE_BITS-1:0] cm_q;
	logic signed [VALUE_BITS-1:0]    vt [VT_N];
	logic signed [VALUE_BITS-1:0]    ht [HT_N];
	logic signed [VALUE_BITS-1:0]    vmax;
	logic signed [VALUE_BITS-1:0]    hmax;
	logic [ROW_BITS:0]               row_nx;
	logic [COLS_BITS+5:0]            col_nx;
	logic [COLS_BITS+5:0]            corner_col_w;

	logic                       out_valid_q;
	logic [VALUE_BITS-1:0]      out_max_q;
	logic [ROW_BITS-1:0]        out_row_q;
	logic [CORNER_COL_BITS-1:0] out_col_q;
	logic                       out_last_q;

	wmf_cfg #(
		.MAX_COLS (MAX_COLS),
		.MAX_WIN_H(MAX_WIN_H),
		.MAX_WIN_W(MAX_WIN_W)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.lim      (lim)
	);

	// handshake
	assign out_free = !out_valid_q || m_tready;
	assign go_s1    = valid_s1 && (!res_s1 || out_free);
	assign s_tready = !valid_s1 || go_s1;
	assign accept   = s_tvalid && s_tready;

	// advance the raster position of the next pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (lim.cfg_wr) begin
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			if (17'(col_q) + 17'd1 >= 17'(lim.cols)) begin
				col_q <= '0;
				row_q <= (17'(row_q) + 17'd1 >= 17'(lim.rows)) ? '0 : row_q + ROW_BITS'(1);
			end else begin
				col_q <= col_q + COL_BITS'(1);
			end
		end
	end

	// first stage: pixel and position beside the line store read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1  <= s_tdata[VALUE_BITS-1:0];
			row_s1 <= row_q;
			col_s1 <= col_q;
		end
	end

	// line stores of the previous rows
	if (MAX_WIN_H > 1) begin : g_ls
		wmf_line_store #(
			.VALUE_BITS(VALUE_BITS),
			.ROWS      (LS_N),
			.DEPTH     (MAX_COLS)
		) u_line_store (
			.clk    (clk),
			.arst_n (arst_n),
			.rd_en  (accept),
			.rd_addr(col_q),
			.wr_en  (go_s1),
			.wr_addr(col_s1),
			.px     (px_s1),
			.lines  (lines)
		);
	end else begin : g_no_ls
		assign lines = '0;
	end

	// vertical then horizontal maximum, each a balanced compare tree;
	// entries outside the window take the seed value so they never win
	always_comb begin
		row_nx   = {1'b0, row_s1} + (ROW_BITS + 1)'(1);
		col_nx   = (COLS_BITS + 6)'(col_s1) + (COLS_BITS + 6)'(1);
		vert_ok  = lim.win_ok && (row_nx >= (ROW_BITS + 1)'(lim.win_h));
		horiz_ok = lim.win_ok && (col_nx >= (COLS_BITS + 6)'(lim.win_w));
		res_s1   = valid_s1 && vert_ok && horiz_ok;
		corner_col_w = col_nx - (COLS_BITS + 6)'(lim.win_w);

		for (int k = 0; k < VT_N; k++) begin
			vt[k] = $signed(px_s1);
		end
		for (int k = 0; k < LS_N; k++) begin
			if (MAX_WIN_H > 1 && vert_ok && (k + 1) < int'(lim.win_h)) begin
				vt[k + 1] = $signed(lines[k]);
			end
		end
		for (int l = 0; l < VT_LVL; l++) begin
			for (int i = 0; i < VT_N; i++) begin
				if ((i & ((2 << l) - 1)) == 0 && vt[i + (1 << l)] > vt[i]) begin
					vt[i] = vt[i + (1 << l)];
				end
			end
		end
		vmax = vt[0];

		for (int k = 0; k < HT_N; k++) begin
			ht[k] = vmax;
		end
		for (int k = 0; k < CM_N; k++) begin
			if (MAX_WIN_W > 1 && horiz_ok && (k + 1) < int'(lim.win_w)) begin
				ht[k + 1] = $signed(cm_q[k]);
			end
		end
		for (int l = 0; l < HT_LVL; l++) begin
			for (int i = 0; i < HT_N; i++) begin
				if ((i & ((2 << l) - 1)) == 0 && ht[i + (1 << l)] > ht[i]) begin
					ht[i] = ht[i + (1 << l)];
				end
			end
		end
		hmax = ht[0];
	end

	// shift the column maxima of the current row
	if (MAX_WIN_W > 1) begin : g_cm
		always_ff @(posedge clk) begin
			if (go_s1) begin
				cm_q[0] <= vmax;
				for (int k = 1; k < CM_N; k++) begin
					cm_q[k] <= cm_q[k-1];
				end
			end
		end
	end else begin : g_no_cm
		assign cm_q = '0;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go_s1 && res_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && res_s1) begin
			out_max_q  <= hmax;
			out_row_q  <= row_nx[ROW_BITS-1:0] - ROW_BITS'(lim.win_h);
			out_col_q  <= corner_col_w[CORNER_COL_BITS-1:0];
			out_last_q <= (row_nx == (ROW_BITS + 1)'(lim.rows))
				&& (col_nx == (COLS_BITS + 6)'(lim.cols));
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = OUT_PAD'({out_col_q, out_row_q, out_max_q});

endmodule

`default_nettype wire

FILE: test/window_max_filter_2d_test.sv
`timescale 1ns / 100ps
// Self-checking bench for window_max_filter_2d: streams pixels under several idle patterns,
// tracks line stores and column maxima alongside the block and checks every window request.
// Depends on wmf_pkg and the window_max_filter_2d RTL.

module window_max_filter_2d_test;

	import wmf_pkg::*;

	localparam int LINE_DEPTH    = 1024;
	localparam int WIN_MAX       = 8;
	localparam int LIMIT_CYCLES  = 400000;
	localparam int SETTLE_CYCLES = 8;
	localparam int PRINT_CAP     = 50;

	// idle patterns per phase
	localparam int MODE_FLOWING        = 0;
	localparam int MODE_SENDER_IDLE    = 1;
	localparam int MODE_RECEIVER_STALL = 2;
	localparam int MODE_BOTH           = 3;

	typedef struct {
		logic [31:0] window_max;
		logic [15:0] corner_row;
		logic [9:0]  corner_col;
		logic        frame_done;
	} window_result_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     s_tvalid = 1'b0;
	wire                      s_tready;
	logic [31:0]              s_tdata = '0;
	wire                      m_tvalid;
	logic                     m_tready = 1'b0;
	wire  [63:0]              m_tdata;
	wire                      m_tlast;
	logic                     cfg_we = 1'b0;
	logic [CFG_INDEX_BITS-1:0] cfg_index = REG_FRAME_ROWS;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;

	// shadow configuration and frame position
	logic [15:0]  cfg_rows = 16'd1;
	logic [10:0]  cfg_cols = 11'd1;
	logic [3:0]   cfg_win_h = 4'd1;
	logic [3:0]   cfg_win_w = 4'd1;
	int unsigned  row_ctr = 0;
	int unsigned  col_ctr = 0;

	// shadow line stores and running column maxima
	logic signed [31:0] line_rows [WIN_MAX-1][LINE_DEPTH];
	logic signed [31:0] column_maxima [WIN_MAX-1];

	logic [31:0]    pixel_queue [$];
	window_result_t pending_windows [$];

	int  sender_idle_pct = 0;
	int  receiver_stall_pct = 0;
	int  mismatch_count = 0;
	int  cycle_count = 0;
	logic pixel_taken = 1'b0;

	window_max_filter_2d u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial forever #2 clk = ~clk;

	// Work out the window request, if any, that one accepted pixel completes
	function automatic void track_pixel(input logic signed [31:0] px);
		int unsigned rows_eff, cols_eff, r, c, h, w;
		bit win_ok;
		logic signed [31:0] vmax, hmax;
		window_result_t res;
		rows_eff = (cfg_rows == 0) ? 1 : cfg_rows;
		cols_eff = (cfg_cols == 0) ? 1 : cfg_cols;
		if (cols_eff > LINE_DEPTH)
			cols_eff = LINE_DEPTH;
		h = cfg_win_h;
		w = cfg_win_w;
		win_ok = (h >= 1) && (h <= WIN_MAX) && (w >= 1) && (w <= WIN_MAX);
		if (col_ctr >= cols_eff)
			col_ctr = 0;
		if (row_ctr >= rows_eff)
			row_ctr = 0;
		r = row_ctr;
		c = col_ctr;

		// vertical maximum down this column
		vmax = px;
		if (win_ok && r + 1 >= h) begin
			for (int k = 0; k + 1 < h; k++)
				if (line_rows[k][c] > vmax)
					vmax = line_rows[k][c];
		end
		for (int k = WIN_MAX - 2; k >= 1; k--)
			line_rows[k][c] = line_rows[k-1][c];
		line_rows[0][c] = px;

		// horizontal maximum across the previous column maxima
		hmax = vmax;
		if (win_ok && c + 1 >= w) begin
			for (int k = 0; k + 1 < w; k++)
				if (column_maxima[k] > hmax)
					hmax = column_maxima[k];
		end
		for (int k = WIN_MAX - 2; k >= 1; k--)
			column_maxima[k] = column_maxima[k-1];
		column_maxima[0] = vmax;

		if (win_ok && r + 1 >= h && c + 1 >= w) begin
			res.window_max = hmax;
			res.corner_row = 16'(r + 1 - h);
			res.corner_col = 10'(c + 1 - w);
			res.frame_done = (r + 1 == rows_eff) && (c + 1 == cols_eff);
			pending_windows.push_back(res);
		end

		// advance the raster position, wrapping at the frame end
		if (c + 1 >= cols_eff) begin
			col_ctr = 0;
			row_ctr = (r + 1 >= rows_eff) ? 0 : r + 1;
		end else begin
			col_ctr = c + 1;
		end
	endfunction

	task automatic report_mismatch(input string what);
		if (mismatch_count < PRINT_CAP)
			$display("[%0t] window check failed: %s", $time, what);
		mismatch_count++;
	endtask

	// Compare one accepted result request against the oldest expected window
	task automatic check_window();
		window_result_t want;
		if (pending_windows.size() == 0) begin
			report_mismatch($sformatf("no window pending, got max %0d corner (%0d,%0d)",
				$signed(m_tdata[31:0]), m_tdata[47:32], m_tdata[57:48]));
			return;
		end
		want = pending_windows.pop_front();
		if (m_tdata[31:0] !== want.window_max)
			report_mismatch($sformatf("window_max %0d, want %0d",
				$signed(m_tdata[31:0]), $signed(want.window_max)));
		if (m_tdata[47:32] !== want.corner_row)
			report_mismatch($sformatf("corner_row %0d, want %0d",
				m_tdata[47:32], want.corner_row));
		if (m_tdata[57:48] !== want.corner_col)
			report_mismatch($sformatf("corner_col %0d, want %0d",
				m_tdata[57:48], want.corner_col));
		if (m_tlast !== want.frame_done)
			report_mismatch($sformatf("frame_done %b, want %b", m_tlast, want.frame_done));
		if (m_tdata[63:58] !== '0)
			report_mismatch($sformatf("tdata padding %b not zero", m_tdata[63:58]));
	endtask

	// Monitor: predict on each pixel request, then check each result request
	always @(posedge clk) begin
		pixel_taken <= s_tvalid && s_tready;
		if (arst_n && s_tvalid && s_tready)
			track_pixel(s_tdata);
		if (arst_n && m_tvalid && m_tready)
			check_window();
	end

	// Driver: present queued pixels and randomise the receiver's ready
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			m_tready <= 1'b0;
		end else begin
			if (!s_tvalid || pixel_taken) begin
				if (pixel_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tdata  <= pixel_queue.pop_front();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			m_tready <= ($urandom_range(99) >= receiver_stall_pct);
		end
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		case (idx)
			REG_FRAME_ROWS:    cfg_rows  = data;
			REG_FRAME_COLS:    cfg_cols  = data[10:0];
			REG_WINDOW_HEIGHT: cfg_win_h = data[3:0];
			REG_WINDOW_WIDTH:  cfg_win_w = data[3:0];
			default: ;
		endcase
		row_ctr = 0;
		col_ctr = 0;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_frame(input logic [15:0] rows, input logic [15:0] cols,
			input logic [15:0] h, input logic [15:0] w);
		write_reg(REG_FRAME_ROWS, rows);
		write_reg(REG_FRAME_COLS, cols);
		write_reg(REG_WINDOW_HEIGHT, h);
		write_reg(REG_WINDOW_WIDTH, w);
	endtask

	task automatic set_idle(input int mode);
		case (mode)
			MODE_SENDER_IDLE:    begin sender_idle_pct = 71; receiver_stall_pct = 0;  end
			MODE_RECEIVER_STALL: begin sender_idle_pct = 0;  receiver_stall_pct = 71; end
			MODE_BOTH:           begin sender_idle_pct = 15; receiver_stall_pct = 15; end
			default:             begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
		endcase
	endtask

	// Hold until every pixel is in and every window is out, then let the pipe drain
	task automatic settle();
		do
			@(posedge clk);
		while (pixel_queue.size() != 0 || s_tvalid || pending_windows.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [31:0] random_pixel();
		case ($urandom_range(7))
			0: return 32'($urandom_range(8)) - 32'd4;
			1: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	task automatic run_phase(input logic [15:0] rows, input logic [15:0] cols,
			input logic [15:0] h, input logic [15:0] w, input int n, input int mode);
		set_idle(mode);
		set_frame(rows, cols, h, w);
		repeat (n) pixel_queue.push_back(random_pixel());
		settle();
	endtask

	initial begin
		logic [31:0] raster_pixels [14];
		int unsigned rows, cols, h, w, n;
		int phase;

		foreach (column_maxima[k])
			column_maxima[k] = '0;
		foreach (line_rows[k, c])
			line_rows[k][c] = '0;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: a one-pixel frame, each pixel is its own window
		set_idle(MODE_FLOWING);
		pixel_queue.push_back(32'h8000_0000);
		pixel_queue.push_back(32'h7FFF_FFFF);
		pixel_queue.push_back(32'hFFFF_FFFF);
		settle();

		// full 3x4 frame with a 2x3 window, then the start of the next frame
		raster_pixels = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0,
			32'h1, 32'h8000_0001, 32'h7FFF_FFFE, 32'hFFFF_FFFB,
			32'h7, 32'h8000_0000, 32'h3, 32'hFFFF_FFFF,
			32'h7FFF_FFFF, 32'h8000_0000};
		set_frame(3, 4, 2, 3);
		foreach (raster_pixels[i])
			pixel_queue.push_back(raster_pixels[i]);
		settle();

		// malformed window sizes: counters run, nothing comes out
		set_frame(2, 2, 0, 9);
		pixel_queue.push_back(32'h1234_5678);
		pixel_queue.push_back(32'h8765_4321);
		settle();
		set_frame(2, 2, 9, 0);
		pixel_queue.push_back(32'h7FFF_FFFF);
		pixel_queue.push_back(32'h8000_0000);
		settle();

		// window taller than the frame
		set_frame(2, 2, 3, 1);
		pixel_queue.push_back(32'h0000_00FF);
		pixel_queue.push_back(32'hFF00_0000);
		settle();

		// extreme settings
		run_phase(16'hFFFF, 1, 8, 1, 30, MODE_SENDER_IDLE);
		run_phase(0, 0, 1, 1, 15, MODE_RECEIVER_STALL);
		run_phase(8, 8, 8, 8, 72, MODE_BOTH);
		run_phase(1, 16'hFFFF, 1, 8, 30, MODE_FLOWING);
		run_phase(4, 1024, 2, 8, 30, MODE_RECEIVER_STALL);

		// random small frames, mostly valid windows with the odd malformed one
		for (phase = 0; phase < 8; phase++) begin
			rows = $urandom_range(1, 10);
			cols = $urandom_range(1, 12);
			if ($urandom_range(9) == 0) begin
				h = $urandom_range(15);
				w = $urandom_range(15);
			end else begin
				h = $urandom_range(1, (rows < WIN_MAX) ? rows : WIN_MAX);
				w = $urandom_range(1, (cols < WIN_MAX) ? cols : WIN_MAX);
			end
			n = rows * cols * $urandom_range(1, 2) + $urandom_range(cols);
			if (n > 45)
				n = 45;
			run_phase(16'(rows), 16'(cols), 16'(h), 16'(w), int'(n), phase % 4);
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
